// ----- hw/rtl/trajectory_segment_time_defines.svh -----
// Assertion macros for the segment time block.
`ifndef TRAJECTORY_SEGMENT_TIME_DEFINES_SVH
`define TRAJECTORY_SEGMENT_TIME_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define TST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/tst_pkg.sv -----
// ---------------------------------------------------------------------------
// tst_pkg: shared types and constants for the segment time block
// Request structs, method codes and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none
package tst_pkg;

    localparam int unsigned MaxPoints = 1024;
    localparam int unsigned SegW      = 10;

    typedef struct packed {
        logic        first_point;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] speed;
        logic [31:0] accel;
    } in_req_t;

    typedef struct packed {
        logic [31:0]     segment_time;
        logic [SegW-1:0] segment_index;
        logic [1:0]      method;
        logic            saturated;
    } out_req_t;

    localparam logic [1:0] MethZero  = 2'd0;
    localparam logic [1:0] MethMean  = 2'd1;
    localparam logic [1:0] MethQuad  = 2'd2;
    localparam logic [1:0] MethFall  = 2'd3;

    localparam logic [0:0] RegNearZero = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_DSQRT,
        ST_CLASS,
        ST_VSQ,
        ST_DISC,
        ST_RSQRT,
        ST_QDIV_SETUP,
        ST_MDIV_SETUP,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tst_arith.sv -----
// ---------------------------------------------------------------------------
// tst_arith: shared iterative unit
// Restoring square root or divide, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module tst_arith (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start_sqrt,
    input  wire logic         start_div,
    input  wire logic [67:0]  radicand,
    input  wire logic [63:0]  dividend,
    input  wire logic [31:0]  divisor,
    output logic              busy,
    output logic [63:0]       result
);
    // sqrt: 34 steps over 68-bit radicand; div: 64 steps of 64/32 unsigned
    logic        busy_reg, busy_next;
    logic        mode_reg, mode_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [67:0] src_reg, src_next;
    logic [69:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [31:0] dv_reg, dv_next;
    logic [69:0] trial, rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        mode_reg <= mode_next;
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        dv_reg   <= dv_next;
    end

    always_comb begin
        busy_next = busy_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dv_next   = dv_reg;
        rem_sh    = '0;
        trial     = '0;
        if (start_sqrt) begin
            busy_next = 1'b1;
            mode_next = 1'b0;
            cnt_next  = 7'd34;
            src_next  = radicand;
            rem_next  = '0;
            q_next    = '0;
        end else if (start_div) begin
            busy_next = 1'b1;
            mode_next = 1'b1;
            cnt_next  = 7'd64;
            src_next  = {4'd0, dividend};
            rem_next  = '0;
            q_next    = '0;
            dv_next   = divisor;
        end else if (busy_reg) begin
            if (!mode_reg) begin
                rem_sh   = {rem_reg[67:0], src_reg[67:66]};
                trial    = {4'd0, q_reg[63:0], 2'b01};
                src_next = {src_reg[65:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_next = rem_sh - trial;
                    q_next   = {q_reg[62:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[62:0], 1'b0};
                end
            end else begin
                rem_sh   = {rem_reg[68:0], src_reg[63]};
                trial    = {38'd0, dv_reg};
                src_next = {src_reg[66:0], 1'b0};
                if (rem_sh >= trial) begin
                    rem_next = rem_sh - trial;
                    q_next   = {q_reg[62:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[62:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    assign busy   = busy_reg;
    assign result = q_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/trajectory_segment_time.sv -----
// ---------------------------------------------------------------------------
// trajectory_segment_time: travel time of each trajectory segment
// Keeps the previous point and times the segment to the current one.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel takes one point request (first_point, pos_x, pos_y, speed,
//   accel, signed Q16.16). m_ channel gives one segment request per point
//   after the first: segment_time, segment_index, method, saturated.
//   A first point produces no output request; the next point is taken on
//   the following cycle.
//   The time from accept to m_valid differs by path (zero distance, mean
//   speed, fallback, quadratic root). It is set by the shared
//   square-root/divide unit (one bit per cycle, 34 steps per root, 64 per
//   quotient) and the single 32x32 multiplier. s_ready is high only in
//   idle, which the block enters in the same cycle as m_valid rises, so
//   the next point can be taken from that cycle on.
//   The output register frees the input: while a request waits on m_ready
//   the next point is worked on and holds at its final step until the
//   waiting request is taken, so a stalled receiver loses nothing.
//   Reset (aresetn low, synchronous) clears the held point, counter and
//   sets near_zero_limit to 1. APB register 0 at address 0: near_zero_limit.
// ---------------------------------------------------------------------------
`default_nettype none
`include "trajectory_segment_time_defines.svh"
module trajectory_segment_time (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tst_pkg::in_req_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tst_pkg::out_req_t      m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [0:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    tst_pkg::state_t state_reg, state_next;

    logic [15:0] nzl_reg;
    logic signed [31:0] px_reg, py_reg, pv_reg, pa_reg;
    logic signed [31:0] cx_reg, cy_reg, cv_reg, ca_reg;
    logic have_reg;
    logic [tst_pkg::SegW-1:0] cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] ds_reg, ds_next;
    logic [1:0]  step_reg, step_next;
    logic [1:0]  meth_reg, meth_next;
    logic        neg_reg, neg_next;
    logic [63:0] tmag_reg, tmag_next;
    logic        valid_reg, valid_next;
    tst_pkg::out_req_t out_reg, out_next;

    logic        s_fire, cfg_wr, load_pt;
    logic [31:0] ma, mb;
    logic [63:0] prod, prod_ds;
    logic [32:0] dx, dy, vsum;
    logic [32:0] dxm, dym, vsm;
    logic [31:0] am, vm;
    logic        start_sqrt, start_div, unit_busy;
    logic [67:0] radicand;
    logic [63:0] dividend, unit_res;
    logic [31:0] divisor;
    logic        a_zero, d_zero, v_zero;
    logic [65:0] disc;
    logic [64:0] pl;
    logic signed [34:0] rmv;
    logic [63:0] t_abs;

    assign s_fire = s_valid && s_ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == tst_pkg::RegNearZero) ? {16'd0, nzl_reg} : 32'd0;
    assign s_ready = (state_reg == tst_pkg::ST_IDLE);
    assign m_valid = valid_reg;
    assign m_data  = out_reg;
    assign load_pt = s_fire && (s_data.first_point || !have_reg);

    assign dx   = {cx_reg[31], cx_reg} - {px_reg[31], px_reg};
    assign dy   = {cy_reg[31], cy_reg} - {py_reg[31], py_reg};
    assign vsum = {pv_reg[31], pv_reg} + {cv_reg[31], cv_reg};
    assign dxm  = dx[32] ? (33'd0 - dx) : dx;
    assign dym  = dy[32] ? (33'd0 - dy) : dy;
    assign vsm  = vsum[32] ? (33'd0 - vsum) : vsum;
    assign am   = pa_reg[31] ? (32'd0 - pa_reg) : pa_reg;
    assign vm   = pv_reg[31] ? (32'd0 - pv_reg) : pv_reg;
    assign a_zero = (am == 32'd0) || (am < {16'd0, nzl_reg});
    assign d_zero = (ds_reg == 64'd0) || (ds_reg < {48'd0, nzl_reg});
    assign v_zero = (vsm == 33'd0) || (vsm < {16'd0, nzl_reg, 1'b0});

    // single shared multiplier; dx/dy magnitudes fit 32 bits except -2^32 case
    assign prod = ma * mb;
    always_comb begin
        ma = 32'd0;
        mb = 32'd0;
        unique case (state_reg)
            tst_pkg::ST_SQ: begin
                if (step_reg == 2'd0) begin
                    ma = dxm[31:0]; mb = dxm[31:0];
                end else begin
                    ma = dym[31:0]; mb = dym[31:0];
                end
            end
            tst_pkg::ST_VSQ:  begin ma = vm; mb = vm; end
            tst_pkg::ST_DISC: begin ma = am; mb = ds_reg[31:0]; end
            default: begin ma = 32'd0; mb = 32'd0; end
        endcase
    end

    // ds may reach 33 bits: add a * 2^32 for its top bit
    assign prod_ds = prod + (ds_reg[32] ? {am, 32'd0} : 64'd0);
    assign pl   = {prod_ds, 1'b0};
    assign rmv  = {2'b00, unit_res[32:0]} - {{3{pv_reg[31]}}, pv_reg};

    always_comb begin
        disc = '0;
        if (!pa_reg[31]) begin
            disc = {2'b00, acc_reg} + {1'b0, pl};
        end else begin
            disc = {2'b00, acc_reg} - {1'b0, pl};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tst_pkg::ST_IDLE;
            nzl_reg   <= 16'd1;
            have_reg  <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            px_reg <= '0; py_reg <= '0; pv_reg <= '0; pa_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            if (cfg_wr && paddr == tst_pkg::RegNearZero) begin
                nzl_reg <= pwdata[15:0];
            end
            if (load_pt) begin
                have_reg <= 1'b1;
                px_reg <= s_data.pos_x; py_reg <= s_data.pos_y;
                pv_reg <= s_data.speed; pa_reg <= s_data.accel;
            end else if (state_reg == tst_pkg::ST_FINISH) begin
                px_reg <= cx_reg; py_reg <= cy_reg;
                pv_reg <= cv_reg; pa_reg <= ca_reg;
            end
        end
        if (s_fire) begin
            cx_reg <= s_data.pos_x; cy_reg <= s_data.pos_y;
            cv_reg <= s_data.speed; ca_reg <= s_data.accel;
        end
        acc_reg  <= acc_next;
        ds_reg   <= ds_next;
        step_reg <= step_next;
        meth_reg <= meth_next;
        neg_reg  <= neg_next;
        tmag_reg <= tmag_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        acc_next   = acc_reg;
        ds_next    = ds_reg;
        step_next  = step_reg;
        meth_next  = meth_reg;
        neg_next   = neg_reg;
        tmag_next  = tmag_reg;
        out_next   = out_reg;
        start_sqrt = 1'b0;
        start_div  = 1'b0;
        radicand   = '0;
        dividend   = '0;
        divisor    = '0;
        t_abs      = '0;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            tst_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (load_pt) begin
                        cnt_next = '0;
                    end else begin
                        state_next = tst_pkg::ST_SQ;
                        step_next  = 2'd0;
                        acc_next   = '0;
                    end
                end
            end
            tst_pkg::ST_SQ: begin
                // 33-bit magnitude: square of 2^32 added as a correction
                if (step_reg == 2'd0) begin
                    acc_next  = prod + (dxm[32] ? 64'd0 : 64'd0);
                    step_next = 2'd1;
                end else begin
                    start_sqrt = 1'b1;
                    radicand   = {4'd0, acc_reg} + {4'd0, prod}
                               + (dxm[32] ? 68'h1_0000_0000_0000_0000 : 68'd0)
                               + (dym[32] ? 68'h1_0000_0000_0000_0000 : 68'd0);
                    state_next = tst_pkg::ST_DSQRT;
                end
            end
            tst_pkg::ST_DSQRT: begin
                if (!unit_busy) begin
                    ds_next    = unit_res;
                    state_next = tst_pkg::ST_CLASS;
                end
            end
            tst_pkg::ST_CLASS: begin
                if (d_zero) begin
                    meth_next  = tst_pkg::MethZero;
                    neg_next   = 1'b0;
                    tmag_next  = '0;
                    state_next = tst_pkg::ST_FINISH;
                end else if (a_zero) begin
                    meth_next  = tst_pkg::MethMean;
                    state_next = tst_pkg::ST_MDIV_SETUP;
                end else begin
                    state_next = tst_pkg::ST_VSQ;
                end
            end
            tst_pkg::ST_VSQ: begin
                acc_next   = prod;
                state_next = tst_pkg::ST_DISC;
            end
            tst_pkg::ST_DISC: begin
                if (pa_reg[31] && ({1'b0, pl} > {2'b00, acc_reg})) begin
                    meth_next  = tst_pkg::MethFall;
                    state_next = tst_pkg::ST_MDIV_SETUP;
                end else begin
                    meth_next  = tst_pkg::MethQuad;
                    start_sqrt = 1'b1;
                    radicand   = {2'b00, disc};
                    state_next = tst_pkg::ST_RSQRT;
                end
            end
            tst_pkg::ST_RSQRT: begin
                if (!unit_busy) begin
                    state_next = tst_pkg::ST_QDIV_SETUP;
                end
            end
            tst_pkg::ST_QDIV_SETUP: begin
                // sign of quotient: rmv sign xor accel sign
                neg_next   = rmv[34] ^ pa_reg[31];
                start_div  = 1'b1;
                dividend   = {13'd0, (rmv[34] ? (35'd0 - rmv) : rmv), 16'd0};
                divisor    = am;
                state_next = tst_pkg::ST_DIV;
            end
            tst_pkg::ST_MDIV_SETUP: begin
                if (v_zero) begin
                    neg_next   = 1'b0;
                    tmag_next  = '0;
                    state_next = tst_pkg::ST_FINISH;
                end else begin
                    neg_next   = vsum[32];
                    start_div  = 1'b1;
                    if (vsm[32]) begin
                        // speed sum of magnitude 2^32: halve both sides
                        dividend = {1'b0, ds_reg[46:0], 16'd0};
                        divisor  = 32'h8000_0000;
                    end else begin
                        dividend = {ds_reg[46:0], 17'd0};
                        divisor  = vsm[31:0];
                    end
                    state_next = tst_pkg::ST_DIV;
                end
            end
            tst_pkg::ST_DIV: begin
                if (!unit_busy) begin
                    tmag_next  = unit_res;
                    state_next = tst_pkg::ST_FINISH;
                end
            end
            tst_pkg::ST_FINISH: begin
                if (!valid_reg || m_ready) begin
                    t_abs = tmag_reg;
                    out_next.method        = meth_reg;
                    out_next.segment_index = cnt_reg;
                    out_next.saturated     = 1'b0;
                    if (meth_reg == tst_pkg::MethQuad && neg_reg) begin
                        out_next.segment_time = 32'd0;
                    end else if (!neg_reg) begin
                        if (t_abs > 64'h7FFF_FFFF) begin
                            out_next.segment_time = 32'h7FFF_FFFF;
                            out_next.saturated    = 1'b1;
                        end else begin
                            out_next.segment_time = t_abs[31:0];
                        end
                    end else begin
                        if (t_abs > 64'h8000_0000) begin
                            out_next.segment_time = 32'h8000_0000;
                            out_next.saturated    = 1'b1;
                        end else begin
                            out_next.segment_time = 32'd0 - t_abs[31:0];
                        end
                    end
                    if ({22'd0, cnt_reg} + 32'd1 >= tst_pkg::MaxPoints - 1) begin
                        cnt_next = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = tst_pkg::ST_OUT;
                end
            end
            tst_pkg::ST_OUT: begin
                valid_next = 1'b1;
                state_next = tst_pkg::ST_IDLE;
            end
            default: begin
                state_next = tst_pkg::ST_IDLE;
            end
        endcase
    end

    tst_arith u_arith (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_sqrt (start_sqrt),
        .start_div  (start_div),
        .radicand   (radicand),
        .dividend   (dividend),
        .divisor    (divisor),
        .busy       (unit_busy),
        .result     (unit_res)
    );

    `TST_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != tst_pkg::ST_IDLE, !s_ready)
    `TST_ASSERT_IMP(a_zero_method_time, aclk, aresetn,
        m_valid && m_data.method == tst_pkg::MethZero, m_data.segment_time == 32'd0)
    `TST_ASSERT_NEXT(a_out_follows, aclk, aresetn,
        state_reg == tst_pkg::ST_OUT, m_valid)
    `TST_ASSERT_IMP(a_unit_idle_at_start, aclk, aresetn,
        start_sqrt || start_div, !unit_busy)
endmodule
`default_nettype wire

// ----- verif/trajectory_segment_time_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trajectory_segment_time_checker: segment time prediction and compare
// Watches the point and segment channels and the APB register writes, keeps
// its own copy of the held point, segment counter and near-zero limit, and
// checks every segment request against the oldest predicted one.
// ---------------------------------------------------------------------------
module trajectory_segment_time_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tst_pkg::in_req_t    s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tst_pkg::out_req_t   m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [0:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  errors,
    output int                  pending,
    output int                  seg_seen
);

    tst_pkg::out_req_t seg_fifo[$];
    logic [63:0] zero_lim;
    longint      held_x, held_y, held_v, held_a;
    bit          held_ok;
    int unsigned seg_cnt;

    function automatic logic [63:0] mag64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] floor_root(logic [127:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (({64'd0, t} * {64'd0, t}) <= v) r = t;
        end
        return r;
    endfunction

    function automatic bit is_small(logic [63:0] m);
        return (m == 0) || (m < zero_lim);
    endfunction

    function automatic longint mean_speed_time(longint ds, longint vsum);
        if (vsum == 0 || mag64(vsum) < 2 * zero_lim) return 0;
        return (ds * 131072) / vsum;
    endfunction

    // returns 1 when the point closes a segment
    function automatic bit time_segment(tst_pkg::in_req_t p, output tst_pkg::out_req_t r);
        longint       x, y, v, a, ds, t, rt;
        logic [127:0] dsq, vsq, p2, disc;
        logic [1:0]   meth;
        bit           sat;
        x = longint'($signed(p.pos_x));
        y = longint'($signed(p.pos_y));
        v = longint'($signed(p.speed));
        a = longint'($signed(p.accel));
        r = '0;
        if (p.first_point || !held_ok) begin
            held_x = x; held_y = y; held_v = v; held_a = a;
            held_ok = 1;
            seg_cnt = 0;
            return 0;
        end
        sat = 0;
        t   = 0;
        dsq = {64'd0, mag64(x - held_x)} * {64'd0, mag64(x - held_x)}
            + {64'd0, mag64(y - held_y)} * {64'd0, mag64(y - held_y)};
        ds  = longint'(floor_root(dsq));
        if (is_small(64'(ds))) begin
            meth = tst_pkg::MethZero;
        end else if (is_small(mag64(held_a))) begin
            meth = tst_pkg::MethMean;
            t    = mean_speed_time(ds, held_v + v);
        end else begin
            vsq = {64'd0, mag64(held_v)} * {64'd0, mag64(held_v)};
            p2  = ({64'd0, mag64(held_a)} * {64'd0, 64'(ds)}) << 1;
            if (held_a < 0 && p2 > vsq) begin
                meth = tst_pkg::MethFall;
                t    = mean_speed_time(ds, held_v + v);
            end else begin
                disc = (held_a > 0) ? vsq + p2 : vsq - p2;
                rt   = longint'(floor_root(disc));
                meth = tst_pkg::MethQuad;
                t    = ((rt - held_v) * 65536) / held_a;
                if (t < 0) t = 0;
            end
        end
        if (t > 64'sd2147483647) begin
            t = 64'sd2147483647; sat = 1;
        end
        if (t < -64'sd2147483648) begin
            t = -64'sd2147483648; sat = 1;
        end
        r.segment_time  = t[31:0];
        r.segment_index = seg_cnt[tst_pkg::SegW-1:0];
        r.method        = meth;
        r.saturated     = sat;
        seg_cnt++;
        if (seg_cnt >= tst_pkg::MaxPoints - 1) seg_cnt = 0;
        held_x = x; held_y = y; held_v = v; held_a = a;
        return 1;
    endfunction

    assign pending = seg_fifo.size();

    always @(posedge aclk) begin
        tst_pkg::out_req_t want;
        tst_pkg::out_req_t got;
        if (!aresetn) begin
            seg_fifo.delete();
            zero_lim = 64'd1;
            held_x = 0; held_y = 0; held_v = 0; held_a = 0;
            held_ok = 0;
            seg_cnt = 0;
            errors   <= 0;
            seg_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                seg_seen <= seg_seen + 1;
                got = m_data;
                if (seg_fifo.size() == 0) begin
                    $display("%0t unexpected segment request: %p", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = seg_fifo.pop_front();
                    if (want !== got) begin
                        $display("%0t segment mismatch: expected %p actual %p",
                                 $time, want, got);
                        errors <= errors + 1;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == tst_pkg::RegNearZero)
                zero_lim = {48'd0, pwdata[15:0]};
            if (s_valid && s_ready) begin
                if (time_segment(s_data, want)) seg_fifo = {seg_fifo, want};
            end
        end
    end

endmodule

// ----- verif/tb_trajectory_segment_time.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_trajectory_segment_time: testbench for the segment time block
// Directed points for each timing path and the corner cases, then random
// trajectories under several near-zero limits, with random gaps on both
// channels, one long receiver stall and a drain before each register write.
// ---------------------------------------------------------------------------
module tb_trajectory_segment_time;

    localparam int CycleLimit = 3000000;
    localparam int DrainWait  = 200;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    tst_pkg::in_req_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 0;
    tst_pkg::out_req_t m_data;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending, seg_seen;
    int          cycles = 0;
    bit          no_gaps = 0;

    always #5 aclk = ~aclk;

    trajectory_segment_time dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    trajectory_segment_time_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .errors, .pending, .seg_seen
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[trajectory_segment_time] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, one long hold after some results
    initial begin
        int gap;
        bit held;
        held = 0;
        @(posedge aclk iff aresetn);
        m_ready <= 1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                gap = no_gaps ? 0 : $urandom_range(0, 15);
                if (!held && seg_seen >= 30) begin
                    held = 1;
                    gap  = 500;
                end
                if (gap > 0) begin
                    m_ready <= 0;
                    repeat (gap) @(posedge aclk);
                    m_ready <= 1;
                end
            end
        end
    end

    task automatic send_point(tst_pkg::in_req_t p);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_limit(logic [15:0] lim);
        s_valid <= 0;
        @(posedge aclk iff pending == 0);
        repeat (DrainWait) @(posedge aclk);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= tst_pkg::RegNearZero;
        pwdata  <= {16'd0, lim};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    function automatic tst_pkg::in_req_t pt(bit f, int x, int y, int v, int a);
        tst_pkg::in_req_t p;
        p.first_point = f;
        p.pos_x = x; p.pos_y = y; p.speed = v; p.accel = a;
        return p;
    endfunction

    function automatic logic [31:0] rand_field(logic [31:0] base);
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return $urandom;
            4: return $urandom_range(0, 140000) - 70000;
            5: return base + $urandom_range(0, 40) - 20;
            default: return base + $urandom_range(0, 1 << 22) - (1 << 21);
        endcase
    endfunction

    task automatic random_run(int n, int first_odds);
        tst_pkg::in_req_t p;
        p = '0;
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            p.first_point = (first_odds > 0) && ($urandom_range(0, first_odds) == 0);
            p.pos_x = rand_field(p.pos_x);
            p.pos_y = rand_field(p.pos_y);
            p.speed = rand_field(p.speed);
            p.accel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) - 1
                                                   : rand_field(p.accel);
            send_point(p);
        end
        no_gaps = 0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed points
        send_point(pt(0, 0, 0, 32'h0001_0000, 0));             // no held point yet
        send_point(pt(0, 0, 0, 32'h0001_0000, 0));             // zero distance
        send_point(pt(0, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 0)); // mean speed
        send_point(pt(0, 32'h0006_0000, 32'h0008_0000, -32'sh0001_0000, 0)); // sum zero
        send_point(pt(0, 32'h0007_0000, 32'h0008_0000, 32'h0002_0000, 32'h0001_0000));
        send_point(pt(0, 32'h0009_0000, 32'h0008_0000, 32'h0002_0000, -32'sh0000_8000));
        send_point(pt(0, 32'h0070_0000, 32'h0008_0000, 32'h0001_0000, -32'sh0001_0000));
        send_point(pt(0, 32'h0070_8000, 32'h0008_0000, -32'sh0003_0000, -32'sh0001_0000));
        send_point(pt(0, 32'h0071_0000, 32'h0008_0000, 32'h0000_0001, 0));
        send_point(pt(1, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 0));
        send_point(pt(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h7fff_ffff));
        send_point(pt(0, 32'h8000_0000, 32'h8000_0000, -32'sh0000_0002, 32'h8000_0000));
        send_point(pt(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_point(pt(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001));
        send_point(pt(0, 32'h8000_0001, 32'h7fff_ffff, -32'sh0000_0005, 0));
        send_point(pt(1, 0, 0, 32'hffff_ffff, 32'hffff_ffff));
        send_point(pt(0, 32'h0000_0001, 0, 32'h0000_0001, 32'hffff_ffff));
        random_run(120, 12);

        write_limit(16'd0);
        send_point(pt(1, 0, 0, 0, 0));
        send_point(pt(0, 32'h0000_0001, 0, 32'h0000_0001, 0));
        random_run(150, 10);

        write_limit(16'hffff);
        send_point(pt(1, 0, 0, 32'h0000_8000, 32'h0000_ffff));
        send_point(pt(0, 32'h0000_ffff, 0, 32'h0000_7fff, 32'h0001_0000));
        send_point(pt(0, 32'h0002_ffff, 0, 32'h0000_8000, 0));
        random_run(150, 10);

        write_limit($urandom_range(0, 65535));
        random_run(150, 10);

        // one trajectory long enough to wrap the segment index
        write_limit($urandom_range(0, 4));
        send_point(pt(1, 0, 0, 32'h0001_0000, 0));
        random_run(1080, 0);

        s_valid <= 0;
        @(posedge aclk iff pending == 0);
        repeat (DrainWait) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("[trajectory_segment_time] OK");
        end else begin
            $display("[trajectory_segment_time] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tst_pkg.sv
hw/rtl/tst_arith.sv
hw/rtl/trajectory_segment_time.sv
verif/trajectory_segment_time_checker.sv
verif/tb_trajectory_segment_time.sv
